FILE: rtl/dpalu_pkg.sv
// Package: payload structs, opcode, condition and shift codes for the data-processing ALU.
`default_nettype none
package dpalu_pkg;

   // Input transaction
   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] rn_value;
      logic [31:0] rm_value;
      logic [31:0] rs_value;
      logic [3:0]  flags_in;
   } dpalu_req_type;

   // Result transaction
   typedef struct packed {
      logic [31:0] result_value;
      logic        write_dest;
      logic [3:0]  dest_index;
      logic [3:0]  flags_out;
      logic        condition_passed;
   } dpalu_rsp_type;

   // Barrel shifter output to the ALU
   typedef struct packed {
      logic [31:0] op2;
      logic        carry;
   } dpalu_shift_type;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
      OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
      OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
      OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
   } alu_op_type;

   typedef enum logic [3:0] {
      COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
      COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
      COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
      COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
   } cond_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   // Flag positions in the NZCV nibble
   localparam int FLAG_N_BIT = 3;
   localparam int FLAG_Z_BIT = 2;
   localparam int FLAG_C_BIT = 1;
   localparam int FLAG_V_BIT = 0;

endpackage
`default_nettype wire

FILE: rtl/arm_data_processing_alu_core.sv
// ARM data-processing execute stage: input register, shifter/ALU, result register.
// A transaction passes the input register, then the result register that drives rsp_valid.
// Throughput: one transaction per cycle when not stalled; the input and result registers form
// a two-entry pipeline, so req_stall rises only when both are full and rsp_stall is high.
// Reset (synchronous, active high) clears both valid bits; payload registers are not reset.
`default_nettype none
module arm_data_processing_alu_core (
   input  var logic                    clock,
   input  var logic                    reset,
   input  var logic                    req_valid,
   output var logic                    req_stall,
   input  var dpalu_pkg::dpalu_req_type req_data,
   output var logic                    rsp_valid,
   input  var logic                    rsp_stall,
   output var dpalu_pkg::dpalu_rsp_type rsp_data
);
   import dpalu_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   dpalu_req_type   in_data_ff,   in_data_in;
   logic            out_valid_ff, out_valid_in;
   dpalu_rsp_type   out_data_ff,  out_data_in;
   dpalu_shift_type shift;
   dpalu_rsp_type   alu_rsp;
   logic            out_move;
   logic            in_move;

   // Datapath
   dpalu_shifter u_shifter (
      .req   (in_data_ff),
      .shift (shift)
   );

   dpalu_alu u_alu (
      .req   (in_data_ff),
      .shift (shift),
      .rsp   (alu_rsp)
   );

   // Pipeline advance
   assign out_move = !out_valid_ff || !rsp_stall;
   assign in_move  = !in_valid_ff || out_move;
   assign req_stall = !in_move;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_move) begin
         out_valid_in = in_valid_ff;
         out_data_in  = alu_rsp;
      end
      if (in_move) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Assertions
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted transaction did not reach the input register");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_move |=> out_valid_ff)
      else $error("input register did not advance into the result register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while the pipeline had room");

   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.condition_passed |->
         out_data_ff.result_value == 32'd0 && !out_data_ff.write_dest)
      else $error("failed condition produced a result or a write");

endmodule
`default_nettype wire

FILE: rtl/dpalu_shifter.sv
// Barrel shifter: forms operand 2 and the shifter carry-out.
`default_nettype none
module dpalu_shifter (
   input  var dpalu_pkg::dpalu_req_type   req,
   output var dpalu_pkg::dpalu_shift_type shift
);
   import dpalu_pkg::*;

   logic [3:0]     rot_half;
   logic [4:0]     rot_amt;
   logic [31:0]    imm_val;
   logic           reg_shift;
   logic [4:0]     imm_amt;
   logic [7:0]     amt;
   shift_kind_type kind;
   logic           cin;
   logic [32:0]    lsl_wide;
   logic [32:0]    lsr_wide;
   logic [32:0]    asr_wide;
   logic [31:0]    ror_val;
   logic [31:0]    rm;

   assign rm        = req.rm_value;
   assign cin       = req.flags_in[FLAG_C_BIT];
   assign kind      = shift_kind_type'(req.instruction[6:5]);
   assign reg_shift = req.instruction[4];
   assign imm_amt   = req.instruction[11:7];
   assign rot_half  = req.instruction[11:8];
   assign rot_amt   = {rot_half, 1'b0};

   // Rotated immediate
   always_comb begin
      logic [63:0] dbl;
      dbl     = {24'd0, req.instruction[7:0], 24'd0, req.instruction[7:0]} >> rot_amt;
      imm_val = dbl[31:0];
   end

   // Shift amount; immediate LSR/ASR of zero mean a shift by 32
   always_comb begin
      if (reg_shift) begin
         amt = req.rs_value[7:0];
      end else if (imm_amt == 5'd0 && (kind == SHIFT_LSR || kind == SHIFT_ASR)) begin
         amt = 8'd32;
      end else begin
         amt = {3'd0, imm_amt};
      end
   end

   // Shifts with the carry bit carried alongside
   assign lsl_wide = {1'b0, rm} << amt;
   assign lsr_wide = {rm, 1'b0} >> amt;
   assign asr_wide = 33'($signed({rm, 1'b0}) >>> amt);

   always_comb begin
      logic [63:0] dbl;
      dbl     = {rm, rm} >> amt[4:0];
      ror_val = dbl[31:0];
   end

   // Operand 2 select
   always_comb begin
      if (req.instruction[25]) begin
         shift.op2   = imm_val;
         shift.carry = (rot_half == 4'd0) ? cin : imm_val[31];
      end else if (amt == 8'd0) begin
         // zero amount: pass through, except immediate ROR #0 is RRX
         if (!reg_shift && kind == SHIFT_ROR) begin
            shift.op2   = {cin, rm[31:1]};
            shift.carry = rm[0];
         end else begin
            shift.op2   = rm;
            shift.carry = cin;
         end
      end else begin
         case (kind)
            SHIFT_LSL: begin
               shift.op2   = lsl_wide[31:0];
               shift.carry = lsl_wide[32];
            end
            SHIFT_LSR: begin
               shift.op2   = lsr_wide[32:1];
               shift.carry = lsr_wide[0];
            end
            SHIFT_ASR: begin
               shift.op2   = asr_wide[32:1];
               shift.carry = asr_wide[0];
            end
            default: begin
               shift.op2   = ror_val;
               shift.carry = ror_val[31];
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dpalu_alu.sv
// Condition check, 32-bit ALU and flag update.
`default_nettype none
module dpalu_alu (
   input  var dpalu_pkg::dpalu_req_type   req,
   input  var dpalu_pkg::dpalu_shift_type shift,
   output var dpalu_pkg::dpalu_rsp_type   rsp
);
   import dpalu_pkg::*;

   alu_op_type  op;
   cond_type    cond;
   logic        fn, fz, fc, fv;
   logic        pass;
   logic        logical;
   logic        is_compare;
   logic [31:0] add_x, add_y;
   logic        add_ci;
   logic [32:0] sum;
   logic        add_v;
   logic [31:0] res;

   assign op   = alu_op_type'(req.instruction[24:21]);
   assign cond = cond_type'(req.instruction[31:28]);
   assign fn   = req.flags_in[FLAG_N_BIT];
   assign fz   = req.flags_in[FLAG_Z_BIT];
   assign fc   = req.flags_in[FLAG_C_BIT];
   assign fv   = req.flags_in[FLAG_V_BIT];

   // Condition field
   always_comb begin
      case (cond)
         COND_EQ: pass = fz;
         COND_NE: pass = !fz;
         COND_CS: pass = fc;
         COND_CC: pass = !fc;
         COND_MI: pass = fn;
         COND_PL: pass = !fn;
         COND_VS: pass = fv;
         COND_VC: pass = !fv;
         COND_HI: pass = fc && !fz;
         COND_LS: pass = !fc || fz;
         COND_GE: pass = (fn == fv);
         COND_LT: pass = (fn != fv);
         COND_GT: pass = !fz && (fn == fv);
         COND_LE: pass = fz || (fn != fv);
         COND_AL: pass = 1'b1;
         default: pass = 1'b0;
      endcase
   end

   assign logical    = op inside {OP_AND, OP_EOR, OP_TST, OP_TEQ,
                                  OP_ORR, OP_MOV, OP_BIC, OP_MVN};
   assign is_compare = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};

   // Adder operand select
   always_comb begin
      case (op)
         OP_SUB, OP_CMP: begin add_x = req.rn_value; add_y = ~shift.op2;    add_ci = 1'b1; end
         OP_RSB:         begin add_x = shift.op2;    add_y = ~req.rn_value; add_ci = 1'b1; end
         OP_ADC:         begin add_x = req.rn_value; add_y = shift.op2;     add_ci = fc;   end
         OP_SBC:         begin add_x = req.rn_value; add_y = ~shift.op2;    add_ci = fc;   end
         OP_RSC:         begin add_x = shift.op2;    add_y = ~req.rn_value; add_ci = fc;   end
         default:        begin add_x = req.rn_value; add_y = shift.op2;     add_ci = 1'b0; end
      endcase
   end

   assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
   assign add_v = (~(add_x[31] ^ add_y[31])) & (add_x[31] ^ sum[31]);

   // Result select
   always_comb begin
      case (op)
         OP_AND, OP_TST: res = req.rn_value & shift.op2;
         OP_EOR, OP_TEQ: res = req.rn_value ^ shift.op2;
         OP_ORR:         res = req.rn_value | shift.op2;
         OP_MOV:         res = shift.op2;
         OP_BIC:         res = req.rn_value & ~shift.op2;
         OP_MVN:         res = ~shift.op2;
         default:        res = sum[31:0];
      endcase
   end

   // Output and flags
   always_comb begin
      rsp.dest_index       = req.instruction[15:12];
      rsp.condition_passed = pass;
      rsp.result_value     = pass ? res : 32'd0;
      rsp.write_dest       = pass && !is_compare;
      rsp.flags_out        = req.flags_in;
      if (pass && req.instruction[20]) begin
         rsp.flags_out[FLAG_N_BIT] = res[31];
         rsp.flags_out[FLAG_Z_BIT] = (res == 32'd0);
         rsp.flags_out[FLAG_C_BIT] = logical ? shift.carry : sum[32];
         rsp.flags_out[FLAG_V_BIT] = logical ? fv : add_v;
      end
   end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the data-processing ALU core: directed table plus random transactions.
`timescale 1ns / 100ps

module tb_top;
   import dpalu_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 40;
   localparam int DRAIN_AT     = 220;
   localparam int QUIET_FROM   = 300;
   localparam int QUIET_TO     = 380;
   localparam int CYCLE_LIMIT  = 100000;

   typedef struct {
      dpalu_req_type stim;
      bit            typed;
      dpalu_rsp_type want;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   dpalu_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   dpalu_rsp_type rsp_data;

   dpalu_rsp_type    expected_rsp_q[$];
   dpalu_rsp_type    offered_expect;
   dpalu_rsp_type    oldest_rsp;
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               hold_count;
   bit               quiet_mode;
   bit               hold_request;
   bit               hold_done;

   arm_data_processing_alu_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Instruction word from its fields
   function automatic logic [31:0] dp_word(cond_type cc, alu_op_type op, bit imm, bit s,
                                           logic [3:0] rn_f, logic [3:0] rd_f,
                                           logic [11:0] op2_f);
      return {cc, 2'b00, imm, op, s, rn_f, rd_f, op2_f};
   endfunction

   // Condition check, barrel shifter and ALU for one instruction
   function automatic dpalu_rsp_type predict_dp_result(dpalu_req_type rq);
      logic [31:0]    word, rm, op2, result, add_a, add_b;
      logic [63:0]    doubled;
      logic [32:0]    sum;
      logic [3:0]     fl;
      logic           add_cin, shift_c, overflow, logical, passed, n, z, c, v;
      int             amount, rot;
      shift_kind_type kind;
      alu_op_type     op;
      dpalu_rsp_type  rsp;

      word = rq.instruction;
      rm   = rq.rm_value;
      fl   = rq.flags_in;
      n    = fl[FLAG_N_BIT];
      z    = fl[FLAG_Z_BIT];
      c    = fl[FLAG_C_BIT];
      v    = fl[FLAG_V_BIT];
      kind = shift_kind_type'(word[6:5]);
      op   = alu_op_type'(word[24:21]);

      case (cond_type'(word[31:28]))
         COND_EQ: passed = z;
         COND_NE: passed = !z;
         COND_CS: passed = c;
         COND_CC: passed = !c;
         COND_MI: passed = n;
         COND_PL: passed = !n;
         COND_VS: passed = v;
         COND_VC: passed = !v;
         COND_HI: passed = c && !z;
         COND_LS: passed = !c || z;
         COND_GE: passed = (n == v);
         COND_LT: passed = (n != v);
         COND_GT: passed = !z && (n == v);
         COND_LE: passed = z || (n != v);
         COND_AL: passed = 1'b1;
         default: passed = 1'b0;
      endcase

      // Operand 2 and shifter carry
      shift_c = c;
      op2     = rm;
      if (word[25]) begin
         rot     = int'({word[11:8], 1'b0});
         doubled = {24'd0, word[7:0], 24'd0, word[7:0]} >> rot;
         op2     = doubled[31:0];
         if (rot != 0) shift_c = op2[31];
      end else begin
         if (!word[4]) amount = int'(word[11:7]);
         else amount = int'(rq.rs_value[7:0]);
         if (!word[4] && amount == 0) begin
            // immediate zero: LSR/ASR mean 32, ROR means RRX
            case (kind)
               SHIFT_LSL: ;
               SHIFT_LSR: begin shift_c = rm[31]; op2 = '0; end
               SHIFT_ASR: begin shift_c = rm[31]; op2 = {32{rm[31]}}; end
               default:   begin shift_c = rm[0]; op2 = {c, rm[31:1]}; end
            endcase
         end else if (amount != 0) begin
            case (kind)
               SHIFT_LSL: begin
                  if (amount < 32) begin
                     shift_c = rm[32 - amount];
                     op2     = rm << amount;
                  end else begin
                     shift_c = (amount == 32) ? rm[0] : 1'b0;
                     op2     = '0;
                  end
               end
               SHIFT_LSR: begin
                  if (amount < 32) begin
                     shift_c = rm[amount - 1];
                     op2     = rm >> amount;
                  end else begin
                     shift_c = (amount == 32) ? rm[31] : 1'b0;
                     op2     = '0;
                  end
               end
               SHIFT_ASR: begin
                  if (amount < 32) begin
                     shift_c = rm[amount - 1];
                     op2     = $signed(rm) >>> amount;
                  end else begin
                     shift_c = rm[31];
                     op2     = {32{rm[31]}};
                  end
               end
               default: begin
                  rot = amount % 32;
                  if (rot == 0) begin
                     shift_c = rm[31];
                  end else begin
                     shift_c = rm[rot - 1];
                     doubled = {rm, rm} >> rot;
                     op2     = doubled[31:0];
                  end
               end
            endcase
         end
      end

      // ALU
      logical = 1'b1;
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      result  = '0;
      case (op)
         OP_AND, OP_TST: result = rq.rn_value & op2;
         OP_EOR, OP_TEQ: result = rq.rn_value ^ op2;
         OP_SUB, OP_CMP: begin logical = 0; add_a = rq.rn_value; add_b = ~op2; add_cin = 1; end
         OP_RSB:         begin logical = 0; add_a = op2; add_b = ~rq.rn_value; add_cin = 1; end
         OP_ADD, OP_CMN: begin logical = 0; add_a = rq.rn_value; add_b = op2; add_cin = 0; end
         OP_ADC:         begin logical = 0; add_a = rq.rn_value; add_b = op2; add_cin = c; end
         OP_SBC:         begin logical = 0; add_a = rq.rn_value; add_b = ~op2; add_cin = c; end
         OP_RSC:         begin logical = 0; add_a = op2; add_b = ~rq.rn_value; add_cin = c; end
         OP_ORR:         result = rq.rn_value | op2;
         OP_MOV:         result = op2;
         OP_BIC:         result = rq.rn_value & ~op2;
         default:        result = ~op2;
      endcase
      sum      = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
      overflow = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);
      if (!logical) result = sum[31:0];

      // Flags and write enable
      rsp.flags_out  = fl;
      rsp.write_dest = 1'b0;
      if (passed) begin
         rsp.write_dest = (op < OP_TST) || (op > OP_CMN);
         if (word[20]) begin
            rsp.flags_out[FLAG_N_BIT] = result[31];
            rsp.flags_out[FLAG_Z_BIT] = (result == 32'd0);
            rsp.flags_out[FLAG_C_BIT] = logical ? shift_c : sum[32];
            rsp.flags_out[FLAG_V_BIT] = logical ? v : overflow;
         end
      end else begin
         result = '0;
      end
      rsp.result_value     = result;
      rsp.dest_index       = word[15:12];
      rsp.condition_passed = passed;
      return rsp;
   endfunction

   // Operand values biased toward the edges
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // Mostly well-formed data-processing words, some raw noise
   function automatic dpalu_req_type random_item();
      dpalu_req_type rq;
      logic [31:0]   rs_word;
      logic [11:0]   op2_f;
      logic [4:0]    amt5;
      cond_type      cc;

      rs_word = $urandom();
      case ($urandom_range(0, 7))
         0:       rs_word[7:0] = 8'd0;
         1:       rs_word[7:0] = 8'd32;
         2:       rs_word[7:0] = 8'd31 + 8'($urandom_range(0, 2));
         3:       rs_word[7:0] = 8'($urandom_range(0, 1) ? 255 : 64);
         4:       rs_word[7:0] = 8'($urandom_range(1, 31));
         default: ;
      endcase
      rq.rn_value = pick_word();
      rq.rm_value = pick_word();
      rq.rs_value = rs_word;
      rq.flags_in = 4'($urandom_range(0, 15));

      if ($urandom_range(0, 99) < 25) begin
         rq.instruction = $urandom();
      end else begin
         cc = ($urandom_range(0, 99) < 40) ? COND_AL : cond_type'($urandom_range(0, 15));
         amt5 = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
         case ($urandom_range(0, 2))
            0:       op2_f = 12'($urandom_range(0, 4095));
            1:       op2_f = {amt5, 2'($urandom_range(0, 3)), 1'b0, 4'($urandom_range(0, 15))};
            default: op2_f = {4'($urandom_range(0, 15)), 1'($urandom_range(0, 9) == 0),
                              2'($urandom_range(0, 3)), 1'b1, 4'($urandom_range(0, 15))};
         endcase
         rq.instruction = dp_word(cc, alu_op_type'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 2) == 0), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  op2_f);
         // immediate form keeps bit 4 as part of imm8, so op2_f covers it already
      end
      return rq;
   endfunction

   task automatic add_row(input logic [31:0] ins, input logic [31:0] rn, input logic [31:0] rm,
                          input logic [31:0] rs, input logic [3:0] fl, input bit typed,
                          input dpalu_rsp_type want);
      directed_row_type row;
      row.stim  = {ins, rn, rm, rs, fl};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Offer one transaction and hold it until accepted
   task automatic send_transaction(input dpalu_req_type item, input dpalu_rsp_type want);
      while (!quiet_mode && !(hold_request && !hold_done) && ($urandom_range(0, 99) < 36)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data       <= item;
      offered_expect  = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Stimulus
   initial begin
      dpalu_req_type item;
      req_valid      = 1'b0;
      req_data       = '0;
      offered_expect = '0;
      reset          = 1'b1;
      quiet_mode     = 1'b0;
      hold_request   = 1'b0;

      // after reset, typed expectations
      add_row(dp_word(COND_AL, OP_MOV, 1, 0, 4'h0, 4'h1, {4'h0, 8'hFF}), 32'h0, 32'h0, 32'h0,
              4'b0110, 1, {32'h0000_00FF, 1'b1, 4'h1, 4'b0110, 1'b1});
      add_row(dp_word(COND_AL, OP_MVN, 1, 1, 4'h0, 4'h2, 12'h000), 32'h0, 32'h0, 32'h0,
              4'b0000, 1, {32'hFFFF_FFFF, 1'b1, 4'h2, 4'b1000, 1'b1});
      // never condition and a failing EQ
      add_row(dp_word(COND_NV, OP_ADD, 0, 1, 4'h1, 4'h3, {5'd0, SHIFT_LSL, 1'b0, 4'h2}),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'b1111, 1,
              {32'h0, 1'b0, 4'h3, 4'b1111, 1'b0});
      add_row(dp_word(COND_EQ, OP_AND, 0, 1, 4'h1, 4'h4, {5'd3, SHIFT_LSR, 1'b0, 4'h2}),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'b1011, 1,
              {32'h0, 1'b0, 4'h4, 4'b1011, 1'b0});
      // rotated immediate
      add_row(dp_word(COND_AL, OP_MOV, 1, 1, 4'h0, 4'h5, {4'h4, 8'hFF}), 32'h0, 32'h0, 32'h0,
              4'b0001, 0, '0);
      // every opcode with S set at the signed edge
      for (int k = 0; k < 16; k++)
         add_row(dp_word(COND_AL, alu_op_type'(k), 0, 1, 4'h5, 4'h6,
                         {5'd0, SHIFT_LSL, 1'b0, 4'h7}),
                 32'h7FFF_FFFF, k[0] ? 32'h1 : 32'h8000_0000, 32'h0, 4'(k), 0, '0);
      // compare without S, LSR #0 as a shift by 32
      add_row(dp_word(COND_AL, OP_CMP, 0, 0, 4'h1, 4'h2, {5'd0, SHIFT_LSR, 1'b0, 4'h3}),
              32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 4'b0101, 0, '0);
      // Rd of 15 with S, ASR #0 on a negative operand
      add_row(dp_word(COND_AL, OP_MOV, 0, 1, 4'h0, 4'hF, {5'd0, SHIFT_ASR, 1'b0, 4'h1}),
              32'h0, 32'h8000_0000, 32'h0, 4'b0000, 0, '0);
      // RRX with carry in set
      add_row(dp_word(COND_AL, OP_MOV, 0, 1, 4'h0, 4'h8, {5'd0, SHIFT_ROR, 1'b0, 4'h1}),
              32'h0, 32'h0000_0003, 32'h0, 4'b0010, 0, '0);
      // register shifts: by zero, by 32, far past 32, multiple of 32 rotate
      add_row(dp_word(COND_AL, OP_ADD, 0, 1, 4'h2, 4'h9, {4'h3, 1'b0, SHIFT_LSL, 1'b1, 4'h1}),
              32'h8000_0000, 32'h8000_0000, 32'hFFFF_FF00, 4'b0010, 0, '0);
      add_row(dp_word(COND_AL, OP_MOV, 0, 1, 4'h0, 4'hA, {4'h3, 1'b0, SHIFT_LSL, 1'b1, 4'h1}),
              32'h0, 32'h0000_0001, 32'd32, 4'b0000, 0, '0);
      add_row(dp_word(COND_AL, OP_MOV, 0, 1, 4'h0, 4'hB, {4'h3, 1'b0, SHIFT_ASR, 1'b1, 4'h1}),
              32'h0, 32'h8000_0000, 32'd200, 4'b0000, 0, '0);
      add_row(dp_word(COND_AL, OP_EOR, 0, 1, 4'h2, 4'hC, {4'h3, 1'b0, SHIFT_ROR, 1'b1, 4'h1}),
              32'h0, 32'h8000_0001, 32'd64, 4'b0000, 0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_transaction(directed_rows[i].stim,
                          directed_rows[i].typed ? directed_rows[i].want
                                                 : predict_dp_result(directed_rows[i].stim));
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_AT) hold_request = 1'b1;
         if (i == DRAIN_AT) drain_results();
         if (i == QUIET_FROM) quiet_mode = 1'b1;
         if (i == QUIET_TO) quiet_mode = 1'b0;
         item = random_item();
         send_transaction(item, predict_dp_result(item));
      end

      drain_results();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Result side back-pressure, with one long hold-off
   initial begin
      rsp_stall  = 1'b0;
      hold_count = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_count++;
            if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
         end else if (quiet_mode) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 36);
         end
      end
   end

   // Scoreboard: check the oldest expectation, then record a new acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t unexpected transaction: actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_rsp = expected_rsp_q.pop_front();
               report_field("result_value", oldest_rsp.result_value, rsp_data.result_value);
               report_field("write_dest", 32'(oldest_rsp.write_dest), 32'(rsp_data.write_dest));
               report_field("dest_index", 32'(oldest_rsp.dest_index), 32'(rsp_data.dest_index));
               report_field("flags_out", 32'(oldest_rsp.flags_out), 32'(rsp_data.flags_out));
               report_field("condition_passed", 32'(oldest_rsp.condition_passed),
                            32'(rsp_data.condition_passed));
            end
         end
         if (req_valid && !req_stall) expected_rsp_q.push_back(offered_expect);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

FILE: files.f
rtl/dpalu_pkg.sv
rtl/dpalu_shifter.sv
rtl/dpalu_alu.sv
rtl/arm_data_processing_alu_core.sv
tb/tb_top.sv
